[src/bert_pkg.sv]
// ----------------------------------------------------------------------------
// bert_pkg: bus error run tracker definitions
// Table size, run limits, command codes and beat structs.
// ----------------------------------------------------------------------------
package bert_pkg;

    localparam int ENTRIES = 5;
    localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

    localparam logic [31:0] RUN_LIMIT     = 32'hFFFF_FF00;
    localparam logic [31:0] NOT_FOUND_RUN = 32'hFFFF_FFFF;

    localparam logic [1:0] MODE_RECORD = 2'd0;
    localparam logic [1:0] MODE_CLEAR  = 2'd1;
    localparam logic [1:0] MODE_QUERY  = 2'd2;

    typedef struct packed {
        logic [1:0] mode;
        logic [7:0] device_address;
        logic       success;
    } t_cmd;

    typedef struct packed {
        logic        found;
        logic [31:0] run_count;
        logic [31:0] max_run;
    } t_result;

endpackage

[src/bus_error_run_tracker.sv]
// ----------------------------------------------------------------------------
// bus_error_run_tracker: per-address bus error run table
// The accepted start beat passes through r_in_valid and r_out_valid to o_valid.
// Throughput: one beat per cycle; busy stays low, since the slot search and
// the counter update settle combinationally between the input and result stages.
// Reset (synchronous, active low) frees every slot and clears all runs.
// The receiver cannot stall; each result is shown for exactly one cycle.
// ----------------------------------------------------------------------------
module bus_error_run_tracker (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  bert_pkg::t_cmd    i_cmd,
    output logic              o_valid,
    output bert_pkg::t_result o_result
);

    logic                       r_in_valid;
    bert_pkg::t_cmd             r_cmd;
    logic                       r_out_valid;
    bert_pkg::t_result          r_result;
    bert_pkg::t_result          n_result;

    logic [7:0]  r_entry_addr [bert_pkg::ENTRIES];
    logic [31:0] r_entry_run  [bert_pkg::ENTRIES];
    logic [31:0] r_entry_max  [bert_pkg::ENTRIES];
    logic [7:0]  n_entry_addr [bert_pkg::ENTRIES];
    logic [31:0] n_entry_run  [bert_pkg::ENTRIES];
    logic [31:0] n_entry_max  [bert_pkg::ENTRIES];

    logic                      find_hit;
    logic [bert_pkg::IDX_W-1:0] find_idx;
    logic                      claim_hit;
    logic [bert_pkg::IDX_W-1:0] claim_idx;
    logic                      slot_hit;
    logic [bert_pkg::IDX_W-1:0] slot_idx;
    logic [31:0]               cur_run;
    logic [31:0]               cur_max;
    logic [31:0]               inc_run;
    logic [31:0]               new_run;
    logic [31:0]               new_max;
    logic                      dup_addr;

    assign busy     = 1'b0;
    assign o_valid  = r_out_valid;
    assign o_result = r_result;

    // search the table: first match, and first free-or-match slot
    always_comb begin
        find_hit  = 1'b0;
        find_idx  = '0;
        claim_hit = 1'b0;
        claim_idx = '0;
        for (int k = bert_pkg::ENTRIES - 1; k >= 0; k--) begin
            if (r_entry_addr[k] == r_cmd.device_address) begin
                find_hit = 1'b1;
                find_idx = bert_pkg::IDX_W'(k);
            end
            if (r_entry_addr[k] == r_cmd.device_address || r_entry_addr[k] == 8'd0) begin
                claim_hit = 1'b1;
                claim_idx = bert_pkg::IDX_W'(k);
            end
        end
    end

    always_comb begin
        for (int k = 0; k < bert_pkg::ENTRIES; k++) begin
            n_entry_addr[k] = r_entry_addr[k];
            n_entry_run[k]  = r_entry_run[k];
            n_entry_max[k]  = r_entry_max[k];
        end

        case (r_cmd.mode)
            bert_pkg::MODE_RECORD: begin
                slot_hit = claim_hit;
                slot_idx = claim_idx;
            end
            default: begin
                slot_hit = find_hit;
                slot_idx = find_idx;
            end
        endcase
        if (r_cmd.device_address == 8'd0) begin
            slot_hit = 1'b0;
        end

        cur_run = r_entry_run[slot_idx];
        cur_max = r_entry_max[slot_idx];
        inc_run = (cur_run < bert_pkg::RUN_LIMIT) ? cur_run + 32'd1 : cur_run;
        new_run = cur_run;
        new_max = cur_max;

        case (r_cmd.mode)
            bert_pkg::MODE_RECORD: begin
                if (r_cmd.success) begin
                    new_run = 32'd0;
                end else begin
                    new_run = inc_run;
                    if (cur_max < inc_run) begin
                        new_max = inc_run;
                    end
                end
            end
            bert_pkg::MODE_CLEAR: begin
                new_run = 32'd0;
            end
            default: begin
                new_run = cur_run;
            end
        endcase

        if (r_in_valid && slot_hit) begin
            n_entry_addr[slot_idx] = r_cmd.device_address;
            n_entry_run[slot_idx]  = new_run;
            n_entry_max[slot_idx]  = new_max;
        end

        if (slot_hit) begin
            n_result.found     = 1'b1;
            n_result.run_count = new_run;
            n_result.max_run   = new_max;
        end else begin
            n_result.found     = 1'b0;
            n_result.run_count = bert_pkg::NOT_FOUND_RUN;
            n_result.max_run   = 32'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            for (int k = 0; k < bert_pkg::ENTRIES; k++) begin
                r_entry_addr[k] <= 8'd0;
                r_entry_run[k]  <= 32'd0;
                r_entry_max[k]  <= 32'd0;
            end
        end else begin
            r_in_valid  <= start && !busy;
            r_out_valid <= r_in_valid;
            for (int k = 0; k < bert_pkg::ENTRIES; k++) begin
                r_entry_addr[k] <= n_entry_addr[k];
                r_entry_run[k]  <= n_entry_run[k];
                r_entry_max[k]  <= n_entry_max[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (start && !busy) begin
            r_cmd <= i_cmd;
        end
        if (r_in_valid) begin
            r_result <= n_result;
        end
    end

    // flag any nonzero address held by two slots
    always_comb begin
        dup_addr = 1'b0;
        for (int a = 0; a < bert_pkg::ENTRIES; a++) begin
            for (int b = a + 1; b < bert_pkg::ENTRIES; b++) begin
                if (r_entry_addr[a] != 8'd0 && r_entry_addr[a] == r_entry_addr[b]) begin
                    dup_addr = 1'b1;
                end
            end
        end
    end

    a_no_dup_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !dup_addr)
        else $error("address held by two slots");

    a_miss_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_result.found |->
            o_result.run_count == bert_pkg::NOT_FOUND_RUN && o_result.max_run == 32'd0)
        else $error("miss result carries entry data");

    a_run_le_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_result.found |->
            o_result.run_count <= o_result.max_run
            && o_result.max_run <= bert_pkg::RUN_LIMIT)
        else $error("run exceeds recorded maximum or limit");

    a_strobe_follows_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> ##1 o_valid)
        else $error("accepted beat produced no result");

endmodule

[verif/bus_error_run_tracker_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bus_error_run_tracker_test: self-checking bench for the bus error run table
// Drives record, clear, query and unused-mode beats with random gaps. A scoreboard keeps
// its own copy of the address table and compares every result strobe.
// ----------------------------------------------------------------------------
module bus_error_run_tracker_test;

    localparam logic [1:0] MODE_UNUSED = 2'd3;
    localparam int         RANDOM_CMDS = 400;
    localparam int         STALL_LIMIT = 1000;
    localparam int         MAX_REPORTS = 10;

    class fault_scoreboard;
        logic [7:0]        slot_addr[bert_pkg::ENTRIES];
        logic [31:0]       slot_run[bert_pkg::ENTRIES];
        logic [31:0]       slot_max[bert_pkg::ENTRIES];
        bert_pkg::t_result expected_q[$];
        int                mismatches;

        function new();
            for (int k = 0; k < bert_pkg::ENTRIES; k++) begin
                slot_addr[k] = '0;
                slot_run[k]  = '0;
                slot_max[k]  = '0;
            end
            mismatches = 0;
        endfunction

        function int find_slot(logic [7:0] addr, bit claim);
            for (int k = 0; k < bert_pkg::ENTRIES; k++) begin
                if (slot_addr[k] == addr || (claim && slot_addr[k] == 8'd0)) return k;
            end
            return -1;
        endfunction

        function void note_command(bert_pkg::t_cmd c);
            bert_pkg::t_result want;
            int                k;
            k = -1;
            if (c.device_address != 8'd0) begin
                case (c.mode)
                    bert_pkg::MODE_RECORD: begin
                        k = find_slot(c.device_address, 1'b1);
                        if (k >= 0) begin
                            slot_addr[k] = c.device_address;
                            if (!c.success) begin
                                if (slot_run[k] < bert_pkg::RUN_LIMIT)
                                    slot_run[k] = slot_run[k] + 32'd1;
                                if (slot_max[k] < slot_run[k]) slot_max[k] = slot_run[k];
                            end else begin
                                slot_run[k] = '0;
                            end
                        end
                    end
                    bert_pkg::MODE_CLEAR: begin
                        k = find_slot(c.device_address, 1'b0);
                        if (k >= 0) slot_run[k] = '0;
                    end
                    default: begin
                        k = find_slot(c.device_address, 1'b0);
                    end
                endcase
            end
            if (k >= 0) begin
                want.found     = 1'b1;
                want.run_count = slot_run[k];
                want.max_run   = slot_max[k];
            end else begin
                want.found     = 1'b0;
                want.run_count = bert_pkg::NOT_FOUND_RUN;
                want.max_run   = '0;
            end
            expected_q.push_back(want);
        endfunction

        function void check_result(bert_pkg::t_result got);
            bert_pkg::t_result want;
            if (expected_q.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("unexpected result: found=%0b run=%h max=%h",
                             got.found, got.run_count, got.max_run);
                return;
            end
            want = expected_q.pop_front();
            if (got.found !== want.found || got.run_count !== want.run_count ||
                got.max_run !== want.max_run) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("mismatch: found %0b/%0b run %h/%h max %h/%h (exp/act)",
                             want.found, got.found, want.run_count, got.run_count,
                             want.max_run, got.max_run);
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic              i_clk;
    logic              i_rst_n;
    logic              start;
    logic              busy;
    bert_pkg::t_cmd    i_cmd;
    logic              o_valid;
    bert_pkg::t_result o_result;

    fault_scoreboard   sb;
    int                idle_cycles = 0;
    int                calm_left;
    logic [7:0]        hot_addr;
    bert_pkg::t_cmd    directed_q[$];

    bus_error_run_tracker DUT (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_cmd    (i_cmd),
        .o_valid  (o_valid),
        .o_result (o_result)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && start && !busy) sb.note_command(i_cmd);
        if (i_rst_n && o_valid) sb.check_result(o_result);
    end

    always @(posedge i_clk) begin
        if ((start && !busy) || o_valid) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    function automatic bert_pkg::t_cmd make_cmd(logic [1:0] mode, logic [7:0] addr,
                                                logic ok);
        bert_pkg::t_cmd c;
        c.mode           = mode;
        c.device_address = addr;
        c.success        = ok;
        return c;
    endfunction

    function automatic logic [7:0] pick_tracked();
        logic [7:0] pool[$];
        for (int k = 0; k < bert_pkg::ENTRIES; k++)
            if (sb.slot_addr[k] != 8'd0) pool.push_back(sb.slot_addr[k]);
        if (pool.size() == 0) return 8'($urandom_range(1, 255));
        return pool[$urandom_range(0, pool.size() - 1)];
    endfunction

    function automatic bert_pkg::t_cmd make_random_cmd();
        int         pick;
        logic [1:0] mode;
        logic [7:0] addr;
        logic       ok;
        pick = $urandom_range(0, 99);
        if (pick < 60)      mode = bert_pkg::MODE_RECORD;
        else if (pick < 75) mode = bert_pkg::MODE_CLEAR;
        else if (pick < 95) mode = bert_pkg::MODE_QUERY;
        else                mode = MODE_UNUSED;
        if ($urandom_range(0, 9) == 0) hot_addr = pick_tracked();
        pick = $urandom_range(0, 99);
        if (pick < 45)      addr = hot_addr;
        else if (pick < 80) addr = pick_tracked();
        else if (pick < 85) addr = 8'd0;
        else                addr = 8'($urandom_range(0, 255));
        if (mode == bert_pkg::MODE_RECORD) ok = ($urandom_range(0, 99) < 20);
        else                               ok = 1'($urandom_range(0, 1));
        return make_cmd(mode, addr, ok);
    endfunction

    task automatic send_cmd(bert_pkg::t_cmd c);
        int gap;
        if (calm_left > 0) begin
            calm_left--;
            gap = 0;
        end else if ($urandom_range(0, 9) == 0) begin
            calm_left = $urandom_range(5, 30);
            gap = 0;
        end else begin
            gap = $urandom_range(0, 5);
        end
        repeat (gap) begin
            start <= 1'b0;
            i_cmd <= bert_pkg::t_cmd'($urandom);
            @(posedge i_clk);
        end
        start <= 1'b1;
        i_cmd <= c;
        do @(posedge i_clk); while (busy);
    endtask

    initial begin
        sb          = new();
        calm_left   = 0;
        hot_addr    = 8'h01;
        i_rst_n    <= 1'b0;
        start      <= 1'b0;
        i_cmd      <= '0;

        // no device: every mode is a no-op
        directed_q.push_back(make_cmd(bert_pkg::MODE_RECORD, 8'h00, 1'b0));
        directed_q.push_back(make_cmd(bert_pkg::MODE_CLEAR,  8'h00, 1'b1));
        directed_q.push_back(make_cmd(bert_pkg::MODE_QUERY,  8'h00, 1'b0));
        directed_q.push_back(make_cmd(MODE_UNUSED,           8'h00, 1'b1));
        // build a run, query with success set, then break the run
        directed_q.push_back(make_cmd(bert_pkg::MODE_RECORD, 8'h01, 1'b0));
        directed_q.push_back(make_cmd(bert_pkg::MODE_RECORD, 8'h01, 1'b0));
        directed_q.push_back(make_cmd(bert_pkg::MODE_QUERY,  8'h01, 1'b1));
        directed_q.push_back(make_cmd(bert_pkg::MODE_RECORD, 8'h01, 1'b1));
        directed_q.push_back(make_cmd(bert_pkg::MODE_QUERY,  8'h01, 1'b0));
        directed_q.push_back(make_cmd(bert_pkg::MODE_RECORD, 8'hFF, 1'b0));
        directed_q.push_back(make_cmd(bert_pkg::MODE_CLEAR,  8'hFF, 1'b0));
        directed_q.push_back(make_cmd(bert_pkg::MODE_RECORD, 8'hFF, 1'b0));
        // clear and query of an absent device
        directed_q.push_back(make_cmd(bert_pkg::MODE_CLEAR,  8'h42, 1'b1));
        directed_q.push_back(make_cmd(bert_pkg::MODE_QUERY,  8'h42, 1'b0));
        // fill the table, then overflow it
        directed_q.push_back(make_cmd(bert_pkg::MODE_RECORD, 8'h80, 1'b1));
        directed_q.push_back(make_cmd(bert_pkg::MODE_RECORD, 8'h55, 1'b0));
        directed_q.push_back(make_cmd(bert_pkg::MODE_RECORD, 8'hAA, 1'b0));
        directed_q.push_back(make_cmd(bert_pkg::MODE_RECORD, 8'h7E, 1'b0));
        directed_q.push_back(make_cmd(bert_pkg::MODE_QUERY,  8'h7E, 1'b0));
        directed_q.push_back(make_cmd(bert_pkg::MODE_RECORD, 8'h7E, 1'b1));
        directed_q.push_back(make_cmd(MODE_UNUSED,           8'h55, 1'b1));
        directed_q.push_back(make_cmd(bert_pkg::MODE_CLEAR,  8'h55, 1'b0));
        directed_q.push_back(make_cmd(bert_pkg::MODE_QUERY,  8'h55, 1'b1));

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_q[n]) send_cmd(directed_q[n]);
        for (int n = 0; n < RANDOM_CMDS; n++) send_cmd(make_random_cmd());

        start <= 1'b0;
        @(posedge i_clk);
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);

        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

[filelist.f]
src/bert_pkg.sv
src/bus_error_run_tracker.sv
verif/bus_error_run_tracker_test.sv
